### hdl/assert_macros.svh
// Shared assertion macros for the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed one cycle later.");

`endif

### hdl/bhist_pkg.sv
package bhist_pkg;

    localparam int BINS        = 256;
    localparam int BIN_AW      = $clog2(BINS);
    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 32;

    typedef logic [BIN_AW-1:0]      t_bin;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TOTAL_WIDTH-1:0] t_total;

    typedef enum logic {
        REQ_COUNT = 1'b0,
        REQ_READ  = 1'b1
    } t_req;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic t_total clamp_total(t_count cnt);
        logic [63:0] ext;
        ext = 64'(cnt);
        if (ext > 64'(t_total'('1))) begin
            return t_total'('1);
        end
        return t_total'(ext);
    endfunction

endpackage

### hdl/bhist_ram.sv
module bhist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/byte_histogram_top.sv
// Byte value histogram with 256 saturating bins.
// The slave channel carries one request per beat: tdata holds the byte value and
// tuser the request type (0 counts the byte, 1 reads the bin named by the byte).
// A count beat produces nothing on the master channel. A read beat produces one
// master beat whose tdata holds the bin index in the low byte and the 32-bit
// count above it; a count above the 32-bit range reads as all ones.
// The counts live in a single-port-read, single-port-write RAM. A request reads
// its bin at the accepting edge; a count request is incremented and written back
// in the following cycle. The value written at the same edge as a read is
// forwarded, so back to back requests on one bin see each other in order.
// Throughput is one beat per cycle, stalls apart. A read result passes the s1 and
// output registers; once valid on the master side, the next edge can take it.
// Reset clears a valid flag per bin, so every bin reads as zero at once and the
// block accepts beats in the first cycle after reset.
// When the receiver stalls with a result waiting, count beats keep flowing, and
// the next read beat waits in the second stage, holding tready low behind it.
module byte_histogram_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // byte_value
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // bin_index, bin_total
);

    `include "assert_macros.svh"

    logic                 r_s1_vld;
    bhist_pkg::t_req      r_s1_req;
    bhist_pkg::t_bin      r_s1_bin;
    logic                 r_fwd_vld;
    bhist_pkg::t_bin      r_fwd_bin;
    bhist_pkg::t_count    r_fwd_cnt;
    logic [bhist_pkg::BINS-1:0] r_valid;
    logic                 r_out_vld;
    bhist_pkg::t_bin      r_out_bin;
    bhist_pkg::t_total    r_out_total;

    logic                 s1_go;
    logic                 accept;
    logic                 wr_en;
    bhist_pkg::t_count    ram_rdata;
    bhist_pkg::t_count    cur_cnt;
    bhist_pkg::t_count    n_cnt;

    assign s1_go  = !r_s1_vld || (r_s1_req == bhist_pkg::REQ_COUNT) ||
                    !r_out_vld || m_axis_tready;
    assign accept = s_axis_tvalid && s1_go;
    assign s_axis_tready = s1_go;

    bhist_ram #(
        .WIDTH (bhist_pkg::COUNT_WIDTH),
        .DEPTH (bhist_pkg::BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_bin),
        .i_wdata (n_cnt),
        .i_re    (accept),
        .i_raddr (s_axis_tdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_vld && (r_fwd_bin == r_s1_bin)) begin
            cur_cnt = r_fwd_cnt;
        end else if (r_valid[r_s1_bin]) begin
            cur_cnt = ram_rdata;
        end else begin
            cur_cnt = '0;
        end
        n_cnt = (cur_cnt == bhist_pkg::COUNT_MAX) ? cur_cnt :
                cur_cnt + bhist_pkg::t_count'(1);
    end

    assign wr_en = r_s1_vld && (r_s1_req == bhist_pkg::REQ_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[r_s1_bin] <= 1'b1;
            end
            if (s1_go) begin
                r_s1_vld  <= s_axis_tvalid;
                r_fwd_vld <= wr_en;
            end
            if (r_s1_vld && (r_s1_req == bhist_pkg::REQ_READ) && s1_go) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_req <= bhist_pkg::t_req'(s_axis_tuser);
            r_s1_bin <= s_axis_tdata;
        end
        if (s1_go) begin
            r_fwd_bin <= r_s1_bin;
            r_fwd_cnt <= n_cnt;
        end
        if (r_s1_vld && (r_s1_req == bhist_pkg::REQ_READ) && s1_go) begin
            r_out_bin   <= r_s1_bin;
            r_out_total <= bhist_pkg::clamp_total(cur_cnt);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_total, r_out_bin};

    `ASSERT_SAME(a_no_write_on_read, r_s1_vld && (r_s1_req == bhist_pkg::REQ_READ), !wr_en)
    `ASSERT_SAME(a_count_never_wraps, wr_en, n_cnt != '0)
    `ASSERT_NEXT(a_stalled_result_holds, r_out_vld && !m_axis_tready,
                 r_out_vld && $stable(r_out_bin) && $stable(r_out_total))
    `ASSERT_NEXT(a_written_bin_valid, wr_en, r_valid[$past(r_s1_bin)])

endmodule
